// File: rtl/core/mqtt_fixed_header_deframer_defines.svh
// Assertion macros used by the checker of the MQTT deframer.
`ifndef MQTT_FIXED_HEADER_DEFRAMER_DEFINES_SVH
`define MQTT_FIXED_HEADER_DEFRAMER_DEFINES_SVH

// Clocked assertion, off while reset is applied.
`define MFHD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also checks across reset.
`define MFHD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/core/mfhd_pkg.sv
package mfhd_pkg;

    // Framer phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    // Byte roles
    localparam logic [1:0] ROLE_HEADER  = 2'd0;
    localparam logic [1:0] ROLE_LENGTH  = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd1;
    localparam logic [1:0] ERR_MALFORMED = 2'd2;

    localparam int LEN_W      = 28;
    localparam int MAXPKT_W   = 29;
    localparam int IDX_W      = 2;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;
    localparam int MAX_LENGTH_BYTES_DEF = 4;

    localparam logic [MAXPKT_W-1:0] MAX_PACKET_RESET = MAXPKT_W'(1024 * 1024);

    // Register indexes (word index = paddr[2])
    localparam logic REG_MAX_PACKET = 1'b0;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic [1:0]       byte_role;
        logic [3:0]       packet_kind;
        logic [LEN_W-1:0] body_length;
        logic             packet_end;
        logic [1:0]       frame_error;
    } result_t;

endpackage

// File: rtl/core/mfhd_cfg.sv
module mfhd_cfg (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mfhd_pkg::PADDR_W-1:0]       paddr,
    input  logic [mfhd_pkg::PDATA_W-1:0]       pwdata,
    output logic [mfhd_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready,
    output logic [mfhd_pkg::MAXPKT_W-1:0]      max_packet_bytes
);

    logic [mfhd_pkg::MAXPKT_W-1:0] max_pkt_reg;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == mfhd_pkg::REG_MAX_PACKET);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_pkt_reg <= mfhd_pkg::MAX_PACKET_RESET;
        end else if (wr_en) begin
            max_pkt_reg <= pwdata[mfhd_pkg::MAXPKT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == mfhd_pkg::REG_MAX_PACKET) begin
            prdata = mfhd_pkg::PDATA_W'(max_pkt_reg);
        end else begin
            prdata = '0;
        end
    end

    assign max_packet_bytes = max_pkt_reg;

endmodule

// File: rtl/core/mfhd_framer.sv
module mfhd_framer #(
    parameter int MAX_LENGTH_BYTES = mfhd_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [7:0]                    rx_byte,
    input  logic [mfhd_pkg::MAXPKT_W-1:0] max_packet_bytes,
    output mfhd_pkg::result_t             res
);

    localparam int LW = mfhd_pkg::LEN_W;
    localparam int MW = mfhd_pkg::MAXPKT_W;
    localparam int IW = mfhd_pkg::IDX_W;

    logic [1:0]    phase_reg, phase_next;
    logic [3:0]    kind_reg, kind_next;
    logic [LW-1:0] accum_reg, accum_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [LW-1:0] left_reg, left_next;

    logic [LW-1:0] group_shifted;
    logic [LW-1:0] accum_sum;
    logic [MW-1:0] total_size;
    logic [LW-1:0] left_dec;
    logic          last_idx;

    // Seven value bits land at bit 7*index.
    assign group_shifted = LW'(rx_byte[6:0]) << (5'(idx_reg) * 5'd7);
    assign accum_sum     = accum_reg + group_shifted;
    assign total_size    = MW'(2) + MW'(idx_reg) + MW'(accum_sum);
    assign left_dec      = left_reg - LW'(1);
    assign last_idx      = ({1'b0, idx_reg} + 3'd1) >= 3'(MAX_LENGTH_BYTES);

    always_comb begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        accum_next = accum_reg;
        idx_next   = idx_reg;
        left_next  = left_reg;
        res.out_byte    = rx_byte;
        res.byte_role   = mfhd_pkg::ROLE_HEADER;
        res.packet_end  = 1'b0;
        res.frame_error = mfhd_pkg::ERR_NONE;
        unique case (phase_reg)
            mfhd_pkg::PH_LENGTH: begin
                res.byte_role = mfhd_pkg::ROLE_LENGTH;
                accum_next    = accum_sum;
                if (!rx_byte[7]) begin
                    if (total_size > max_packet_bytes) begin
                        res.frame_error = mfhd_pkg::ERR_TOO_LARGE;
                        phase_next      = mfhd_pkg::PH_HEADER;
                    end else if (accum_sum == '0) begin
                        res.packet_end = 1'b1;
                        phase_next     = mfhd_pkg::PH_HEADER;
                    end else begin
                        left_next  = accum_sum;
                        phase_next = mfhd_pkg::PH_PAYLOAD;
                    end
                end else if (last_idx) begin
                    // too many continuation bytes: drop back to header
                    res.frame_error = mfhd_pkg::ERR_MALFORMED;
                    phase_next      = mfhd_pkg::PH_HEADER;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            mfhd_pkg::PH_PAYLOAD: begin
                res.byte_role = mfhd_pkg::ROLE_PAYLOAD;
                left_next     = left_dec;
                if (left_dec == '0) begin
                    res.packet_end = 1'b1;
                    phase_next     = mfhd_pkg::PH_HEADER;
                end
            end
            default: begin
                // header byte; the unused phase code lands here too
                kind_next  = rx_byte[7:4];
                accum_next = '0;
                idx_next   = '0;
                left_next  = '0;
                phase_next = mfhd_pkg::PH_LENGTH;
            end
        endcase
        res.packet_kind = kind_next;
        res.body_length = accum_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= mfhd_pkg::PH_HEADER;
            kind_reg  <= '0;
            accum_reg <= '0;
            idx_reg   <= '0;
            left_reg  <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            accum_reg <= accum_next;
            idx_reg   <= idx_next;
            left_reg  <= left_next;
        end
    end

endmodule

// File: rtl/core/mqtt_fixed_header_deframer.sv
// Pipeline: a request accepted on s_ is held in the input register; the framer works
// out its result, which loads into the result register when that one is free or
// being drained. Throughput: one byte per clock unless m_ready stalls the output;
// the framer state updates once per byte as it moves on to the result register.
// Reset (aresetn low, synchronous): both stages empty, framer awaits a header
// byte, max_packet_bytes returns to 1048576.
module mqtt_fixed_header_deframer #(
    parameter int MAX_LENGTH_BYTES = mfhd_pkg::MAX_LENGTH_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mfhd_pkg::PADDR_W-1:0]        paddr,
    input  logic [mfhd_pkg::PDATA_W-1:0]        pwdata,
    output logic [mfhd_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_rx_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_out_byte,
    output logic [1:0]                          m_byte_role,
    output logic [3:0]                          m_packet_kind,
    output logic [mfhd_pkg::LEN_W-1:0]          m_body_length,
    output logic                                m_packet_end,
    output logic [1:0]                          m_frame_error
);

    logic [mfhd_pkg::MAXPKT_W-1:0] max_packet_bytes;
    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          out_valid_reg;
    mfhd_pkg::result_t             out_res_reg;
    mfhd_pkg::result_t             frame_res;
    logic                          advance;

    mfhd_cfg u_cfg (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .max_packet_bytes (max_packet_bytes)
    );

    mfhd_framer #(
        .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
    ) u_framer (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .rx_byte          (in_byte_reg),
        .max_packet_bytes (max_packet_bytes),
        .res              (frame_res)
    );

    // Move the held byte on when the result register is free or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= frame_res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_byte    = out_res_reg.out_byte;
    assign m_byte_role   = out_res_reg.byte_role;
    assign m_packet_kind = out_res_reg.packet_kind;
    assign m_body_length = out_res_reg.body_length;
    assign m_packet_end  = out_res_reg.packet_end;
    assign m_frame_error = out_res_reg.frame_error;

endmodule

// File: rtl/core/mfhd_checker.sv
`include "mqtt_fixed_header_deframer_defines.svh"

module mfhd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [7:0]                          m_out_byte,
    input logic [1:0]                          m_byte_role,
    input logic [3:0]                          m_packet_kind,
    input logic [mfhd_pkg::LEN_W-1:0]          m_body_length,
    input logic                                m_packet_end,
    input logic [1:0]                          m_frame_error
);

    logic        out_stall;
    logic [44:0] out_fields;
    logic        has_err;
    logic        is_hdr;
    logic        hdr_clean;
    logic        is_pay;
    logic        pay_clean;

    assign out_stall  = m_valid && !m_ready;
    assign out_fields = {m_out_byte, m_byte_role, m_packet_kind, m_body_length,
                         m_packet_end, m_frame_error};
    assign has_err    = (m_frame_error != mfhd_pkg::ERR_NONE);
    assign is_hdr     = (m_byte_role == mfhd_pkg::ROLE_HEADER);
    assign hdr_clean  = (m_body_length == '0) && !m_packet_end
                        && (m_frame_error == mfhd_pkg::ERR_NONE);
    assign is_pay     = (m_byte_role == mfhd_pkg::ROLE_PAYLOAD);
    assign pay_clean  = (m_frame_error == mfhd_pkg::ERR_NONE) && (m_body_length != '0);

    // Hold a stalled result.
    `MFHD_ASSERT(a_out_hold, (out_stall |=> m_valid && $stable(out_fields)), "result moved")

    // An errored byte never closes a packet.
    `MFHD_ASSERT(a_err_no_end, (m_valid && has_err |-> !m_packet_end), "end on errored byte")

    // A header byte starts a packet with no length and no error.
    `MFHD_ASSERT(a_header_clean, (m_valid && is_hdr |-> hdr_clean), "bad header result")

    // Payload bytes carry no error and a nonzero length.
    `MFHD_ASSERT(a_payload_clean, (m_valid && is_pay |-> pay_clean), "bad payload result")

    // Reset empties the result stage.
    `MFHD_ASSERT_ALWAYS(a_reset_empty, (!aresetn |=> !m_valid), "result valid after reset")

endmodule

bind mqtt_fixed_header_deframer mfhd_checker u_mfhd_checker (.*);
